// File: hw/rtl/bpq_pkg.sv
// Package for the bounded priority queue: depth, widths, command, error and
// cell operation codes, and the stored entry type. No dependencies.
package bpq_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int LIM_W = 5;
  // Width that holds both the count and the 5-bit limit register.
  localparam int CMP_W = (CNT_W > LIM_W) ? CNT_W : LIM_W;

  typedef enum logic [1:0] {
    CMD_ENQ = 2'd0,
    CMD_DEQ = 2'd1,
    CMD_CLR = 2'd2,
    CMD_NOP = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_SHIFT  = 2'd2
  } cell_op_e;

  typedef struct packed {
    logic signed [31:0] val;
    logic signed [31:0] pri;
  } entry_t;

  // Broadcast from the control to every cell.
  typedef struct packed {
    cell_op_e op;
    entry_t   item;
  } cell_ctl_t;

endpackage

// File: hw/rtl/bpq_cell.sv
// One slot of the sorted chain: holds an entry and moves it, takes the new
// entry or takes a neighbor's entry. Depends on bpq_pkg.
module bpq_cell (
  input  logic                clk,
  input  bpq_pkg::cell_ctl_t  ctl,
  input  logic                occupied,
  input  logic                left_ge,
  input  bpq_pkg::entry_t     left_entry,
  input  bpq_pkg::entry_t     right_entry,
  output logic                ge,
  output bpq_pkg::entry_t     entry,
  output bpq_pkg::entry_t     entry_next
);

  // This slot stays ahead of the new entry.
  assign ge = occupied && (entry.pri >= ctl.item.pri);

  always_comb begin
    entry_next = entry;
    unique case (ctl.op)
      bpq_pkg::OP_INSERT: begin
        if (!ge) begin
          entry_next = left_ge ? ctl.item : left_entry;
        end
      end
      bpq_pkg::OP_SHIFT: entry_next = right_entry;
      default:           entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// File: hw/rtl/bounded_priority_queue.sv
// Top level of the bounded priority queue: control, limit register, result
// register and the chain of bpq_cell slots. Depends on bpq_pkg, bpq_cell.
//
//  channel  direction  handshake           payload
//  cfg      in         cfg_we              cfg_wdata (capacity_limit)
//  in       in         in_valid/in_stall   cmd, item_value, item_priority
//  out      out        out_valid/out_stall head_value, head_priority,
//                                          entry_count, is_empty, is_full,
//                                          error_code
//
// Each word is first captured into a register; at the chain step that follows,
// every slot compares its priority with the new one and shifts in parallel,
// and the result register loads at that same edge. The 32-bit signed compare in
// each cell sets the path. A result waiting under out_stall holds the chain
// step, so in_stall stays high until the result register frees up.
// Reset (rst, synchronous) empties the queue and sets the limit to 16; the
// slot contents are left as they are.
module bounded_priority_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic signed [31:0] item_value,
  input  logic signed [31:0] item_priority,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] head_value,
  output logic signed [31:0] head_priority,
  output logic [4:0]         entry_count,
  output logic               is_empty,
  output logic               is_full,
  output logic [1:0]         error_code
);

  localparam int DEPTH = bpq_pkg::DEPTH;
  localparam int CNT_W = bpq_pkg::CNT_W;
  localparam int CMP_W = bpq_pkg::CMP_W;

  // Control and captured word.
  logic                   busy;
  bpq_pkg::cmd_e          cmd_q;
  bpq_pkg::entry_t        item_q;
  logic [4:0]             capacity_limit;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  bpq_pkg::err_e          err;
  bpq_pkg::cell_ctl_t     ctl;
  logic                   step;
  logic [CMP_W-1:0]       eff_limit;
  logic                   full_now;
  logic                   full_next;

  // Chain signals.
  bpq_pkg::entry_t        cell_q    [DEPTH];
  bpq_pkg::entry_t        cell_next [DEPTH];
  logic [DEPTH-1:0]       ge;
  logic [DEPTH-1:0]       occupied;

  assign in_stall = busy;
  // Advance the chain only when the result register can take the outcome.
  assign step = busy && !(out_valid && out_stall);

  // Clamp the limit to the storage depth.
  always_comb begin
    if (CMP_W'(capacity_limit) < CMP_W'(DEPTH)) begin
      eff_limit = CMP_W'(capacity_limit);
    end else begin
      eff_limit = CMP_W'(DEPTH);
    end
  end

  assign full_now  = CMP_W'(count) >= eff_limit;
  assign full_next = CMP_W'(count_next) >= eff_limit;

  // Decode the captured command into a chain operation.
  always_comb begin
    count_next = count;
    err        = bpq_pkg::ERR_OK;
    ctl.op     = bpq_pkg::OP_HOLD;
    ctl.item   = item_q;
    unique case (cmd_q)
      bpq_pkg::CMD_ENQ: begin
        if (full_now) begin
          err = bpq_pkg::ERR_FULL;
        end else begin
          ctl.op     = bpq_pkg::OP_INSERT;
          count_next = count + CNT_W'(1);
        end
      end
      bpq_pkg::CMD_DEQ: begin
        if (count == '0) begin
          err = bpq_pkg::ERR_EMPTY;
        end else begin
          ctl.op     = bpq_pkg::OP_SHIFT;
          count_next = count - CNT_W'(1);
        end
      end
      bpq_pkg::CMD_CLR: count_next = '0;
      default:          count_next = count;
    endcase
    // Hold every slot unless this is the stepping cycle.
    if (!step) begin
      ctl.op = bpq_pkg::OP_HOLD;
    end
  end

  // The chain: slot 0 is the head. Slot 0 sees a virtual higher neighbor
  // that always ranks ahead; the last slot shifts in its own entry.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic            left_ge_i;
    bpq_pkg::entry_t left_i;
    bpq_pkg::entry_t right_i;

    assign occupied[i] = count > CNT_W'(i);

    if (i == 0) begin : g_first
      assign left_ge_i = 1'b1;
      assign left_i    = item_q;
    end else begin : g_mid
      assign left_ge_i = ge[i-1];
      assign left_i    = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_i = cell_q[i];
    end else begin : g_inner
      assign right_i = cell_q[i+1];
    end

    bpq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (occupied[i]),
      .left_ge     (left_ge_i),
      .left_entry  (left_i),
      .right_entry (right_i),
      .ge          (ge[i]),
      .entry       (cell_q[i]),
      .entry_next  (cell_next[i])
    );
  end

  // Control state and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      out_valid      <= 1'b0;
      count          <= '0;
      capacity_limit <= 5'd16;
    end else begin
      if (cfg_we) begin
        capacity_limit <= cfg_wdata;
      end
      if (in_valid && !in_stall) begin
        busy <= 1'b1;
      end
      // A step refills the result register even as the old word leaves.
      if (step) begin
        busy      <= 1'b0;
        out_valid <= 1'b1;
        count     <= count_next;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Capture the word; payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_q      <= bpq_pkg::cmd_e'(cmd);
      item_q.val <= item_value;
      item_q.pri <= item_priority;
    end
    if (step) begin
      if (count_next != '0) begin
        head_value    <= cell_next[0].val;
        head_priority <= cell_next[0].pri;
      end else begin
        head_value    <= '0;
        head_priority <= '0;
      end
      entry_count <= 5'(CMP_W'(count_next));
      is_empty    <= (count_next == '0);
      is_full     <= full_next;
      error_code  <= err;
    end
  end

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    CMP_W'(count) <= CMP_W'(DEPTH))
    else $error("stored count exceeds depth");

  a_step_done : assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid && !busy)
    else $error("chain step did not deliver a result");

  a_empty_head : assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> head_value == 0 && head_priority == 0)
    else $error("empty queue shows a head entry");

  a_err_empty : assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code == bpq_pkg::ERR_EMPTY |-> is_empty && entry_count == 0)
    else $error("dequeue refusal with entries stored");
`endif

endmodule

// File: dv/tb.sv
// Self-checking bench for bounded_priority_queue: random and directed command
// words against an in-bench sorted-queue predictor held in a small scoreboard.
// Depends on bpq_pkg and the bounded_priority_queue RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One result word as the block reports it after a step.
  typedef struct packed {
    logic signed [31:0] head_value;
    logic signed [31:0] head_priority;
    logic [4:0]         entry_count;
    logic               is_empty;
    logic               is_full;
    bpq_pkg::err_e      error_code;
  } queue_status_t;

  // Sorted-insert predictor plus the FIFO of expected status words.
  class queue_scoreboard;
    logic signed [31:0] slot_val [bpq_pkg::DEPTH];
    logic signed [31:0] slot_pri [bpq_pkg::DEPTH];
    int unsigned        held;
    logic [4:0]         limit_reg;
    queue_status_t      expected_status [$];
    int                 fails;
    int                 checked;

    function new();
      held      = 0;
      limit_reg = 5'd16;
      fails     = 0;
      checked   = 0;
    endfunction

    function void set_limit(logic [4:0] v);
      limit_reg = v;
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    function bit at_limit();
      int unsigned eff;
      eff = (limit_reg < bpq_pkg::DEPTH) ? limit_reg : bpq_pkg::DEPTH;
      return held >= eff;
    endfunction

    // Apply one accepted command word and queue the status it must produce.
    function void note_word(bpq_pkg::cmd_e c, logic signed [31:0] v,
                            logic signed [31:0] p);
      int unsigned   pos;
      bpq_pkg::err_e e;
      queue_status_t s;
      e = bpq_pkg::ERR_OK;
      unique case (c)
        bpq_pkg::CMD_ENQ: begin
          if (at_limit() || held >= bpq_pkg::DEPTH) begin
            e = bpq_pkg::ERR_FULL;
          end else begin
            // Go behind every entry of greater or equal priority.
            pos = 0;
            while (pos < held && slot_pri[pos] >= p) pos++;
            for (int i = held; i > pos; i--) begin
              slot_val[i] = slot_val[i-1];
              slot_pri[i] = slot_pri[i-1];
            end
            slot_val[pos] = v;
            slot_pri[pos] = p;
            held++;
          end
        end
        bpq_pkg::CMD_DEQ: begin
          if (held == 0) begin
            e = bpq_pkg::ERR_EMPTY;
          end else begin
            for (int i = 0; i + 1 < held; i++) begin
              slot_val[i] = slot_val[i+1];
              slot_pri[i] = slot_pri[i+1];
            end
            held--;
          end
        end
        bpq_pkg::CMD_CLR: held = 0;
        default: ;
      endcase
      s.head_value    = (held != 0) ? slot_val[0] : 32'sd0;
      s.head_priority = (held != 0) ? slot_pri[0] : 32'sd0;
      s.entry_count   = held[4:0];
      s.is_empty      = (held == 0);
      s.is_full       = at_limit();
      s.error_code    = e;
      expected_status.push_back(s);
    endfunction

    task report(string what, logic [31:0] got_v, logic [31:0] want_v);
      $display("%0t word %0d %s: got %h expected %h", $realtime, checked, what, got_v,
               want_v);
      fails++;
    endtask

    task check_result(queue_status_t got);
      queue_status_t want;
      if (expected_status.size() == 0) begin
        report("unexpected word", 32'(got.entry_count), 32'd0);
        return;
      end
      want = expected_status.pop_front();
      if (got.head_value !== want.head_value)
        report("head_value", got.head_value, want.head_value);
      if (got.head_priority !== want.head_priority)
        report("head_priority", got.head_priority, want.head_priority);
      if (got.entry_count !== want.entry_count)
        report("entry_count", 32'(got.entry_count), 32'(want.entry_count));
      if (got.is_empty !== want.is_empty)
        report("is_empty", 32'(got.is_empty), 32'(want.is_empty));
      if (got.is_full !== want.is_full)
        report("is_full", 32'(got.is_full), 32'(want.is_full));
      if (got.error_code !== want.error_code)
        report("error_code", 32'(got.error_code), 32'(want.error_code));
      checked++;
    endtask
  endclass

  // Hold every input at a known value from time zero.
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [4:0]         cfg_wdata = 5'd0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         cmd = bpq_pkg::CMD_NOP;
  logic signed [31:0] item_value = 32'sd0;
  logic signed [31:0] item_priority = 32'sd0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] head_value;
  logic signed [31:0] head_priority;
  logic [4:0]         entry_count;
  logic               is_empty;
  logic               is_full;
  logic [1:0]         error_code;

  queue_scoreboard sb;
  int              send_quiet = 0;
  int              recv_quiet = 0;
  int              words_seen = 0;
  bit              filling = 1'b1;

  bounded_priority_queue u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .item_value    (item_value),
    .item_priority (item_priority),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .head_value    (head_value),
    .head_priority (head_priority),
    .entry_count   (entry_count),
    .is_empty      (is_empty),
    .is_full       (is_full),
    .error_code    (error_code)
  );

  always #6 clk = ~clk;

  // Random idle gap before each word, with occasional stretches of back-to-back words.
  function automatic int draw_gap(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 5) == 0) begin
      quiet = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  // Mostly a handful of nearby priorities so ties are common; sometimes the
  // extremes or a fully random one.
  function automatic logic signed [31:0] pick_priority();
    unique case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2, 3:    return $urandom;
      default: return $signed($urandom_range(0, 8)) - 4;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_value();
    unique case ($urandom_range(0, 15))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Offer one word and hold it until the block takes it. Called at a rising
  // edge; returns at the edge that accepted the word.
  task send_word(bpq_pkg::cmd_e c, logic signed [31:0] v, logic signed [31:0] p);
    int gap;
    gap = draw_gap(send_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    cmd           <= c;
    item_value    <= v;
    item_priority <= p;
    do @(posedge clk); while (in_stall);
    sb.note_word(c, v, p);
  endtask

  // Drop valid and wait for every expected status word to come back.
  task drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // Let the chain step settle before touching the register.
    repeat (3) @(posedge clk);
  endtask

  // Write the limit register; only called while the queue is idle.
  task write_limit(logic [4:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_limit(v);
  endtask

  // Random words in fill and drain bursts so the queue swings between empty
  // and full; a few clears and unused commands mixed in.
  task run_phase(int words);
    int            r;
    bpq_pkg::cmd_e c;
    repeat (words) begin
      if ($urandom_range(0, 11) == 0) filling = ~filling;
      r = $urandom_range(0, 99);
      if (r < 2)
        c = bpq_pkg::CMD_NOP;
      else if (r < 5)
        c = bpq_pkg::CMD_CLR;
      else if (filling)
        c = (r < 75) ? bpq_pkg::CMD_ENQ : bpq_pkg::CMD_DEQ;
      else
        c = (r < 30) ? bpq_pkg::CMD_ENQ : bpq_pkg::CMD_DEQ;
      send_word(c, pick_value(), pick_priority());
    end
  endtask

  // Receiver: check every accepted status word, stall at random, and once
  // hold off long enough that the block backs up and stalls its input.
  initial begin
    int            gap;
    queue_status_t got;
    gap = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        got.head_value    = head_value;
        got.head_priority = head_priority;
        got.entry_count   = entry_count;
        got.is_empty      = is_empty;
        got.is_full       = is_full;
        got.error_code    = bpq_pkg::err_e'(error_code);
        sb.check_result(got);
        words_seen++;
        gap = (words_seen == 150) ? 80 : draw_gap(recv_quiet);
      end
      out_stall <= (gap > 0);
      if (gap > 0) gap--;
    end
  end

  // Main sequence: reset, directed corner cases, then random phases across
  // several limit settings.
  initial begin
    int unsigned limits [9];
    limits = '{16, 31, 5, 1, 0, 12, 17, 2, 16};
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    write_limit(5'd16);

    // Empty dequeue, priority extremes, equal-priority order, unused command,
    // then clear and dequeue after clear.
    send_word(bpq_pkg::CMD_DEQ, 32'sd5, 32'sd5);
    send_word(bpq_pkg::CMD_ENQ, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_word(bpq_pkg::CMD_ENQ, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_word(bpq_pkg::CMD_ENQ, 32'sd0, 32'sd0);
    send_word(bpq_pkg::CMD_ENQ, -32'sd1, 32'sd0);
    send_word(bpq_pkg::CMD_ENQ, 32'sd1, -32'sd1);
    send_word(bpq_pkg::CMD_NOP, $urandom, $urandom);
    send_word(bpq_pkg::CMD_DEQ, $urandom, $urandom);
    send_word(bpq_pkg::CMD_DEQ, $urandom, $urandom);
    send_word(bpq_pkg::CMD_CLR, $urandom, $urandom);
    send_word(bpq_pkg::CMD_DEQ, $urandom, $urandom);
    drain();

    // Small limit: fill it, then one enqueue too many.
    write_limit(5'd3);
    send_word(bpq_pkg::CMD_ENQ, 32'sd10, 32'sd5);
    send_word(bpq_pkg::CMD_ENQ, 32'sd11, 32'sd5);
    send_word(bpq_pkg::CMD_ENQ, 32'sd12, 32'sd9);
    send_word(bpq_pkg::CMD_ENQ, 32'sd13, 32'sd100);
    drain();

    // Lower the limit below the stored count: entries stay, dequeue works.
    write_limit(5'd1);
    send_word(bpq_pkg::CMD_ENQ, 32'sd14, 32'sd1);
    send_word(bpq_pkg::CMD_DEQ, $urandom, $urandom);
    drain();

    // Zero limit: always full, never accepts.
    write_limit(5'd0);
    send_word(bpq_pkg::CMD_CLR, $urandom, $urandom);
    send_word(bpq_pkg::CMD_ENQ, 32'sd15, 32'sd2);
    send_word(bpq_pkg::CMD_DEQ, $urandom, $urandom);
    drain();

    // Limit above the storage depth.
    write_limit(5'd31);
    send_word(bpq_pkg::CMD_ENQ, 32'sd16, -32'sd7);
    send_word(bpq_pkg::CMD_ENQ, 32'sd17, 32'sd7);
    drain();

    foreach (limits[k]) begin
      write_limit(limits[k][4:0]);
      run_phase(45);
      drain();
    end

    // Bounded wait for stragglers, then a quiet spell before the final check.
    for (int n = 0; n < 4000 && sb.pending() != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) sb.report("missing words", sb.pending(), 32'd0);

    if (sb.fails == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #3ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
